// ===== design/ptt_pkg.sv =====
// ---------------------------------------------------------------------------
// ptt_pkg: shared types and constants for the periodic timer table
// codes for actions, result kinds and the controller states
// ---------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int unsigned SlotsDefault = 16;
  localparam int unsigned TimeW        = 64;
  localparam int unsigned PeriodW      = 31;
  localparam int unsigned HandleW      = 4;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_POLL   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_REMOVED  = 3'd1,
    KIND_FIRED    = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_FULL     = 3'd4,
    KIND_NOTFOUND = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE_SCAN,
    ST_AD_RD,
    ST_AD_WR,
    ST_AD_HEAD,
    ST_RM_RD,
    ST_RM_CMP,
    ST_DR_RD,
    ST_DR_WR,
    ST_P_RD,
    ST_P_SL,
    ST_P_CHK,
    ST_P_UPD,
    ST_P_DIV,
    ST_P_WB,
    ST_SEND
  } state_e;

endpackage

`default_nettype wire

// ===== design/ptt_in_if.sv =====
// ---------------------------------------------------------------------------
// ptt_in_if: request channel of the periodic timer table
// valid/ready handshake with one request per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  handle;
  logic [30:0] interval;
  logic        repeat_req;
  logic [63:0] now;

  modport source (output valid, action, handle, interval, repeat_req, now, input ready);
  modport sink   (input valid, action, handle, interval, repeat_req, now, output ready);
endinterface

`default_nettype wire

// ===== design/ptt_out_if.sv =====
// ---------------------------------------------------------------------------
// ptt_out_if: result channel of the periodic timer table
// valid/ready handshake with one result per beat
// ---------------------------------------------------------------------------
`default_nettype none

interface ptt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [3:0] slot;
  logic       last;

  modport source (output valid, kind, slot, last, input ready);
  modport sink   (input valid, kind, slot, last, output ready);
endinterface

`default_nettype wire

// ===== design/periodic_timer_table.sv =====
// ---------------------------------------------------------------------------
// periodic_timer_table: table of SLOTS software timers
// add reports full or scans for the lowest free slot, shifts the age list
// and puts the new entry at its head; remove walks the age list and closes
// the gap; poll visits each live entry, sends a beat per fired one, works
// out the serial remainder for a repeating entry with nonzero period, unlinks
// a fired one-shot and ends with a done beat; one request at a time is taken
// reset clears valid bits, entry count, controller and output valid bit only
// ---------------------------------------------------------------------------
`default_nettype none

module periodic_timer_table
  import ptt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  ptt_in_if.sink    in_i,
  ptt_out_if.source out_o
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned MW = TimeW + PeriodW + 1;

  // controller state
  state_e            state_q, state_d;
  state_e            ret_q, ret_d;     // where SEND goes after the beat
  state_e            dret_q, dret_d;   // where the list drop returns
  logic [CW-1:0]     i_q, i_d;         // age list position being visited
  logic [CW-1:0]     j_q, j_d;         // shift position
  logic [CW-1:0]     count_q, count_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [SW-1:0]     slot_q, slot_d;

  // pending result
  kind_e             res_kind_q, res_kind_d;
  logic [3:0]        res_slot_q, res_slot_d;
  logic              res_last_q, res_last_d;

  // entry under work
  logic [TimeW-1:0]   dl_q, dl_d;
  logic [PeriodW-1:0] per_q, per_d;
  logic               rpt_q, rpt_d;

  // serial remainder of elapsed time by period
  logic [TimeW-1:0]   div_q, div_d;
  logic [PeriodW-1:0] rem_q, rem_d;
  logic [5:0]         bit_q, bit_d;

  // latched request
  logic [3:0]         handle_q;
  logic [PeriodW-1:0] interval_q;
  logic               rep_q;
  logic [TimeW-1:0]   now_q;

  // output register
  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [3:0]        out_slot_q;
  logic              out_last_q;
  logic              out_load;

  // memories: age list and slot records {deadline, period, repeats}
  logic [SW-1:0]     age_mem [SLOTS];
  logic              age_we;
  logic [SW-1:0]     age_waddr, age_wdata, age_raddr, age_rd_q;
  logic [MW-1:0]     sm_mem [SLOTS];
  logic              sm_we;
  logic [SW-1:0]     sm_waddr, sm_raddr;
  logic [MW-1:0]     sm_wdata, sm_rd_q;

  logic              accept;
  logic [SW+3:0]     handle_ext;
  logic              handle_ok;
  logic [SW+3:0]     slot_ext;
  logic [PeriodW:0]  trial;
  logic [PeriodW:0]  trial_sub;
  logic [CW-1:0]     j_next;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign handle_ext = {{SW{1'b0}}, in_i.handle};
  assign handle_ok  = (handle_ext < (SW + 4)'(SLOTS)) && valid_q[handle_ext[SW-1:0]];
  assign slot_ext   = {4'b0, slot_q};
  assign trial      = {rem_q, div_q[TimeW-1]};
  assign trial_sub  = trial - {1'b0, per_q};
  assign j_next     = j_q + CW'(1);

  assign out_o.valid = out_valid_q;
  assign out_o.kind  = out_kind_q;
  assign out_o.slot  = out_slot_q;
  assign out_o.last  = out_last_q;

  always_ff @(posedge clk_i) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_rd_q <= age_mem[age_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      sm_mem[sm_waddr] <= sm_wdata;
    end
    sm_rd_q <= sm_mem[sm_raddr];
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    dret_d     = dret_q;
    i_d        = i_q;
    j_d        = j_q;
    count_d    = count_q;
    valid_d    = valid_q;
    slot_d     = slot_q;
    res_kind_d = res_kind_q;
    res_slot_d = res_slot_q;
    res_last_d = res_last_q;
    dl_d       = dl_q;
    per_d      = per_q;
    rpt_d      = rpt_q;
    div_d      = div_q;
    rem_d      = rem_q;
    bit_d      = bit_q;
    out_load   = 1'b0;
    age_we     = 1'b0;
    age_waddr  = j_q[SW-1:0];
    age_wdata  = age_rd_q;
    age_raddr  = i_q[SW-1:0];
    sm_we      = 1'b0;
    sm_waddr   = slot_q;
    sm_wdata   = {now_q, per_q, rpt_q};
    sm_raddr   = age_rd_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_last_d = 1'b1;
          ret_d      = ST_IDLE;
          i_d        = '0;
          unique case (action_e'(in_i.action))
            ACT_ADD: begin
              if (count_q >= CW'(SLOTS)) begin
                res_kind_d = KIND_FULL;
                res_slot_d = 4'd0;
                state_d    = ST_SEND;
              end else begin
                state_d = ST_FREE_SCAN;
              end
            end
            ACT_REMOVE: begin
              res_slot_d = in_i.handle;
              if (handle_ok) begin
                res_kind_d = KIND_REMOVED;
                valid_d[handle_ext[SW-1:0]] = 1'b0;
                state_d    = ST_RM_RD;
              end else begin
                res_kind_d = KIND_NOTFOUND;
                state_d    = ST_SEND;
              end
            end
            ACT_POLL: begin
              state_d = ST_P_RD;
            end
            ACT_CLEAR: begin
              valid_d = '0;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end

      // lowest free slot, one valid bit a cycle
      ST_FREE_SCAN: begin
        if (!valid_q[i_q[SW-1:0]]) begin
          slot_d   = i_q[SW-1:0];
          valid_d[i_q[SW-1:0]] = 1'b1;
          sm_we    = 1'b1;
          sm_waddr = i_q[SW-1:0];
          sm_wdata = {now_q + {{(TimeW - PeriodW){1'b0}}, interval_q}, interval_q, rep_q};
          if (count_q == '0) begin
            state_d = ST_AD_HEAD;
          end else begin
            j_d     = count_q - CW'(1);
            state_d = ST_AD_RD;
          end
        end else begin
          i_d = i_q + CW'(1);
        end
      end

      ST_AD_RD: begin
        age_raddr = j_q[SW-1:0];
        state_d   = ST_AD_WR;
      end

      ST_AD_WR: begin
        age_we    = 1'b1;
        age_waddr = j_next[SW-1:0];
        if (j_q == '0) begin
          state_d = ST_AD_HEAD;
        end else begin
          j_d     = j_q - CW'(1);
          state_d = ST_AD_RD;
        end
      end

      ST_AD_HEAD: begin
        age_we     = 1'b1;
        age_waddr  = '0;
        age_wdata  = slot_q;
        count_d    = count_q + CW'(1);
        res_kind_d = KIND_ADDED;
        res_slot_d = slot_ext[3:0];
        state_d    = ST_SEND;
      end

      ST_RM_RD: begin
        state_d = ST_RM_CMP;
      end

      ST_RM_CMP: begin
        if ({4'b0, age_rd_q} == {{SW{1'b0}}, handle_q}) begin
          j_d     = i_q;
          dret_d  = ST_SEND;
          state_d = ST_DR_RD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = ST_RM_RD;
        end
      end

      // close the gap at position j in the age list
      ST_DR_RD: begin
        if (j_next >= count_q) begin
          count_d = count_q - CW'(1);
          state_d = dret_q;
        end else begin
          age_raddr = j_next[SW-1:0];
          state_d   = ST_DR_WR;
        end
      end

      ST_DR_WR: begin
        age_we  = 1'b1;
        j_d     = j_next;
        state_d = ST_DR_RD;
      end

      ST_P_RD: begin
        if (i_q >= count_q) begin
          res_kind_d = KIND_DONE;
          res_slot_d = 4'd0;
          res_last_d = 1'b1;
          ret_d      = ST_IDLE;
          state_d    = ST_SEND;
        end else begin
          state_d = ST_P_SL;
        end
      end

      ST_P_SL: begin
        slot_d  = age_rd_q;
        state_d = ST_P_CHK;
      end

      ST_P_CHK: begin
        dl_d  = sm_rd_q[MW-1 -: TimeW];
        per_d = sm_rd_q[PeriodW:1];
        rpt_d = sm_rd_q[0];
        if (sm_rd_q[MW-1 -: TimeW] > now_q) begin
          i_d     = i_q + CW'(1);
          state_d = ST_P_RD;
        end else begin
          res_kind_d = KIND_FIRED;
          res_slot_d = slot_ext[3:0];
          res_last_d = 1'b0;
          ret_d      = ST_P_UPD;
          state_d    = ST_SEND;
        end
      end

      ST_P_UPD: begin
        if (!rpt_q) begin
          valid_d[slot_q] = 1'b0;
          j_d     = i_q;
          dret_d  = ST_P_RD;
          state_d = ST_DR_RD;
        end else if (per_q == '0) begin
          sm_we   = 1'b1;
          i_d     = i_q + CW'(1);
          state_d = ST_P_RD;
        end else begin
          div_d   = now_q - dl_q;
          rem_d   = '0;
          bit_d   = '0;
          state_d = ST_P_DIV;
        end
      end

      // restoring remainder, one dividend bit a cycle
      ST_P_DIV: begin
        div_d = {div_q[TimeW-2:0], 1'b0};
        if (!trial_sub[PeriodW]) begin
          rem_d = trial_sub[PeriodW-1:0];
        end else begin
          rem_d = trial[PeriodW-1:0];
        end
        bit_d = bit_q + 6'd1;
        if (bit_q == 6'd63) begin
          state_d = ST_P_WB;
        end
      end

      // next deadline is now, or now plus what is left of the period
      ST_P_WB: begin
        sm_we = 1'b1;
        if (rem_q != '0) begin
          sm_wdata = {now_q + {{(TimeW - PeriodW){1'b0}}, per_q - rem_q}, per_q, rpt_q};
        end
        i_d     = i_q + CW'(1);
        state_d = ST_P_RD;
      end

      ST_SEND: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ret_q;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      dret_q      <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      count_q     <= '0;
      valid_q     <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      dret_q  <= dret_d;
      i_q     <= i_d;
      j_q     <= j_d;
      count_q <= count_d;
      valid_q <= valid_d;
      bit_q   <= bit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    res_kind_q <= res_kind_d;
    res_slot_q <= res_slot_d;
    res_last_q <= res_last_d;
    dl_q       <= dl_d;
    per_q      <= per_d;
    rpt_q      <= rpt_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    if (accept) begin
      handle_q   <= in_i.handle;
      interval_q <= in_i.interval;
      rep_q      <= in_i.repeat_req;
      now_q      <= in_i.now;
    end
    if (out_load) begin
      out_kind_q <= res_kind_q;
      out_slot_q <= res_slot_q;
      out_last_q <= res_last_q;
    end
  end

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> count_q == CW'($countones(valid_q)))
    else $error("entry count differs from live slots");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.action == ACT_CLEAR |=> count_q == '0 && valid_q == '0)
    else $error("clear left live entries");

  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == KIND_FIRED |-> !out_last_q)
    else $error("fired beat marked last");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(SLOTS))
    else $error("entry count beyond table size");

endmodule

`default_nettype wire
